### hdl/srtf_pkg.sv
// Shared constants and beat types for the SRTF scheduler.
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int ARRIVAL_BITS  = 16;
  localparam int BURST_BITS    = 12;
  localparam int INDEX_BITS    = 6;
  localparam int TIME_OUT_BITS = 18;
  localparam int TOTAL_BITS    = 22;

  typedef struct packed {
    logic [ARRIVAL_BITS-1:0] arrival_time;
    logic [BURST_BITS-1:0]   burst_length;
    logic                    last_process;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]    process_index;
    logic [TIME_OUT_BITS-1:0] start_time;
    logic [TIME_OUT_BITS-1:0] finish_time;
    logic [TIME_OUT_BITS-1:0] turnaround_time;
    logic [TIME_OUT_BITS-1:0] waiting_time;
    logic [TIME_OUT_BITS-1:0] response_time;
    logic [TOTAL_BITS-1:0]    total_waiting;
    logic [TOTAL_BITS-1:0]    total_turnaround;
    logic                     last_result;
  } out_item_t;

  // scan unit control and status
  typedef struct packed {
    logic clear;
    logic valid;
  } scan_ctl_t;

  typedef struct packed {
    logic found;
    logic have_next;
  } scan_stat_t;

endpackage

`default_nettype wire

### hdl/srtf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/srtf_scan.sv
// Shared compare unit: one entry per beat, tracks best pick and next arrival.
`timescale 1ns / 1ps
`default_nettype none

module srtf_scan #(
  parameter int IDX_W  = 4,
  parameter int TIME_W = 17
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire srtf_pkg::scan_ctl_t               ctl,
  input  wire logic [IDX_W-1:0]                  idx,
  input  wire logic [srtf_pkg::BURST_BITS-1:0]   rem,
  input  wire logic [srtf_pkg::ARRIVAL_BITS-1:0] arr,
  input  wire logic [TIME_W-1:0]                 cur_time,
  output srtf_pkg::scan_stat_t                   stat,
  output logic      [IDX_W-1:0]                  pick,
  output logic      [srtf_pkg::BURST_BITS-1:0]   best,
  output logic      [TIME_W-1:0]                 next_arr
);

  logic                            found_r, found_nxt;
  logic                            have_r, have_nxt;
  logic [IDX_W-1:0]                pick_r, pick_nxt;
  logic [srtf_pkg::BURST_BITS-1:0] best_r, best_nxt;
  logic [TIME_W-1:0]               next_r, next_nxt;
  logic [TIME_W-1:0]               arr_ext;
  logic                            live, arrived, take, fut;

  always_comb begin
    arr_ext = TIME_W'(arr);
    live    = (rem != '0);
    arrived = (arr_ext <= cur_time);
    // strict less-than keeps the lowest index on a tie
    take    = live && arrived && (!found_r || (rem < best_r));
    fut     = live && !arrived && (!have_r || (arr_ext < next_r));

    found_nxt = found_r;
    have_nxt  = have_r;
    pick_nxt  = pick_r;
    best_nxt  = best_r;
    next_nxt  = next_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
      have_nxt  = 1'b0;
    end else if (ctl.valid) begin
      if (take) begin
        found_nxt = 1'b1;
        pick_nxt  = idx;
        best_nxt  = rem;
      end
      if (fut) begin
        have_nxt = 1'b1;
        next_nxt = arr_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      found_r <= found_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pick_r <= pick_nxt;
    best_r <= best_nxt;
    next_r <= next_nxt;
  end

  assign stat.found     = found_r;
  assign stat.have_next = have_r;
  assign pick           = pick_r;
  assign best           = best_r;
  assign next_arr       = next_r;

endmodule

`default_nettype wire

### hdl/srtf_scheduler_simulation.sv
// SRTF scheduler top level: load, event-driven simulation, per-process report.
// Load: one process per cycle while loading (stall low in the load phase only).
// Simulation: a run step is a scan through the shared compare unit, then the
// RUN and UPD states; an idle jump scans, then jumps to the next arrival; at
// most 2n steps per set. Report: n beats per set, each OADDR, ORD, OWT, OSUM,
// OHOLD until out_stall is low. Synchronous active-low reset clears control,
// counters and started flags; the process stores are loaded before any read.
`timescale 1ns / 1ps
`default_nettype none

module srtf_scheduler_simulation #(
  parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire srtf_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output srtf_pkg::out_item_t      out_data
);

  localparam int IDX_W  = $clog2(MAX_PROCS);
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int AB_W   = srtf_pkg::ARRIVAL_BITS + srtf_pkg::BURST_BITS;
  localparam int BUR_W  = srtf_pkg::BURST_BITS;
  localparam int TIME_W = $clog2((2 ** srtf_pkg::ARRIVAL_BITS) +
                                 MAX_PROCS * (2 ** srtf_pkg::BURST_BITS));

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_RUN   = 4'd2;
  localparam logic [3:0] S_UPD   = 4'd3;
  localparam logic [3:0] S_OADDR = 4'd4;
  localparam logic [3:0] S_ORD   = 4'd5;
  localparam logic [3:0] S_OWT   = 4'd6;
  localparam logic [3:0] S_OSUM  = 4'd7;
  localparam logic [3:0] S_OHOLD = 4'd8;

  logic [3:0]                      state_r, state_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [CNT_W-1:0]                done_r, done_nxt;
  logic [IDX_W-1:0]                idx_r, idx_nxt;
  logic [IDX_W-1:0]                rd_idx_r, rd_idx_nxt;
  logic                            rd_vld_r, rd_vld_nxt;
  logic                            iss_done_r, iss_done_nxt;
  logic [TIME_W-1:0]               time_r, time_nxt;
  logic [MAX_PROCS-1:0]            started_r, started_nxt;
  logic [BUR_W-1:0]                run_r, run_nxt;
  logic [TIME_W-1:0]               tat_r, tat_nxt;
  logic [TIME_W-1:0]               resp_r, resp_nxt;
  logic [TIME_W-1:0]               wt_r, wt_nxt;
  logic [TIME_W-1:0]               st_r, st_nxt;
  logic [TIME_W-1:0]               fin_r, fin_nxt;
  logic [BUR_W-1:0]                bur_r, bur_nxt;
  logic [srtf_pkg::TOTAL_BITS-1:0] totw_r, totw_nxt;
  logic [srtf_pkg::TOTAL_BITS-1:0] tott_r, tott_nxt;
  logic                            out_valid_r, out_valid_nxt;
  srtf_pkg::out_item_t             out_r, out_nxt;

  logic                            in_acc;
  logic [BUR_W-1:0]                bur_adj;
  logic [IDX_W-1:0]                last_idx;
  logic [IDX_W-1:0]                load_idx;

  logic                            ab_we;
  logic [AB_W-1:0]                 ab_rdata;
  logic                            rem_we;
  logic [IDX_W-1:0]                rem_waddr;
  logic [BUR_W-1:0]                rem_wdata;
  logic [BUR_W-1:0]                rem_rdata;
  logic                            st_we;
  logic [TIME_W-1:0]               st_rdata;
  logic                            fin_we;
  logic [TIME_W-1:0]               fin_rdata;

  logic [srtf_pkg::ARRIVAL_BITS-1:0] arr_rd;
  logic [BUR_W-1:0]                bur_rd;

  srtf_pkg::scan_ctl_t             scan_ctl;
  srtf_pkg::scan_stat_t            scan_stat;
  logic [IDX_W-1:0]                pick;
  logic [BUR_W-1:0]                best;
  logic [TIME_W-1:0]               next_arr;

  logic [TIME_W-1:0]               gap;
  logic [BUR_W-1:0]                rem_new;
  logic [TIME_W-1:0]               time_sum;
  logic                            is_last_out;

  assign in_acc   = in_valid && !in_stall;
  assign bur_adj  = (in_data.burst_length == '0) ? BUR_W'(1) : in_data.burst_length;
  assign last_idx = IDX_W'(count_r - CNT_W'(1));
  assign load_idx = count_r[IDX_W-1:0];
  assign arr_rd   = ab_rdata[AB_W-1 -: srtf_pkg::ARRIVAL_BITS];
  assign bur_rd   = ab_rdata[BUR_W-1:0];

  assign gap         = next_arr - time_r;
  assign rem_new     = best - run_r;
  assign time_sum    = time_r + TIME_W'(run_r);
  assign is_last_out = (idx_r == last_idx);

  // store write ports
  assign ab_we     = in_acc;
  assign rem_we    = in_acc || (state_r == S_UPD);
  assign rem_waddr = in_acc ? load_idx : pick;
  assign rem_wdata = in_acc ? bur_adj : rem_new;
  assign st_we     = (state_r == S_UPD) && !started_r[pick];
  assign fin_we    = (state_r == S_UPD) && (rem_new == '0);

  srtf_ram #(.WIDTH(AB_W), .DEPTH(MAX_PROCS), .AW(IDX_W)) u_ab_ram (
    .clk   (clk),
    .we    (ab_we),
    .waddr (load_idx),
    .wdata ({in_data.arrival_time, bur_adj}),
    .raddr (idx_r),
    .rdata (ab_rdata)
  );

  srtf_ram #(.WIDTH(BUR_W), .DEPTH(MAX_PROCS), .AW(IDX_W)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (idx_r),
    .rdata (rem_rdata)
  );

  srtf_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROCS), .AW(IDX_W)) u_start_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (pick),
    .wdata (time_r),
    .raddr (idx_r),
    .rdata (st_rdata)
  );

  srtf_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROCS), .AW(IDX_W)) u_finish_ram (
    .clk   (clk),
    .we    (fin_we),
    .waddr (pick),
    .wdata (time_sum),
    .raddr (idx_r),
    .rdata (fin_rdata)
  );

  srtf_scan #(.IDX_W(IDX_W), .TIME_W(TIME_W)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .idx      (rd_idx_r),
    .rem      (rem_rdata),
    .arr      (arr_rd),
    .cur_time (time_r),
    .stat     (scan_stat),
    .pick     (pick),
    .best     (best),
    .next_arr (next_arr)
  );

  // clear the compare unit on every entry into a scan
  assign scan_ctl.clear = (state_nxt == S_SCAN) && (state_r != S_SCAN);
  assign scan_ctl.valid = rd_vld_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    done_nxt      = done_r;
    idx_nxt       = idx_r;
    rd_idx_nxt    = idx_r;
    rd_vld_nxt    = 1'b0;
    iss_done_nxt  = iss_done_r;
    time_nxt      = time_r;
    started_nxt   = started_r;
    run_nxt       = run_r;
    tat_nxt       = tat_r;
    resp_nxt      = resp_r;
    wt_nxt        = wt_r;
    st_nxt        = st_r;
    fin_nxt       = fin_r;
    bur_nxt       = bur_r;
    totw_nxt      = totw_r;
    tott_nxt      = tott_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          count_nxt = count_r + CNT_W'(1);
          if (in_data.last_process || (count_r == CNT_W'(MAX_PROCS - 1))) begin
            state_nxt    = S_SCAN;
            idx_nxt      = '0;
            iss_done_nxt = 1'b0;
          end
        end
      end
      S_SCAN: begin
        // address issue runs ahead of the compare, across the registered RAM read
        if (!iss_done_r) begin
          rd_vld_nxt = 1'b1;
          if (idx_r == last_idx) begin
            iss_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        if (rd_vld_r && (rd_idx_r == last_idx)) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (scan_stat.found) begin
          // run until done or until the next arrival
          if (scan_stat.have_next && (gap < TIME_W'(best))) begin
            run_nxt = BUR_W'(gap);
          end else begin
            run_nxt = best;
          end
          state_nxt = S_UPD;
        end else if (scan_stat.have_next) begin
          time_nxt     = next_arr;
          state_nxt    = S_SCAN;
          idx_nxt      = '0;
          iss_done_nxt = 1'b0;
        end else begin
          state_nxt = S_OADDR;
          idx_nxt   = '0;
        end
      end
      S_UPD: begin
        started_nxt[pick] = 1'b1;
        time_nxt          = time_sum;
        if ((rem_new == '0) && ((done_r + CNT_W'(1)) == count_r)) begin
          done_nxt  = done_r + CNT_W'(1);
          state_nxt = S_OADDR;
          idx_nxt   = '0;
        end else begin
          if (rem_new == '0) begin
            done_nxt = done_r + CNT_W'(1);
          end
          state_nxt    = S_SCAN;
          idx_nxt      = '0;
          iss_done_nxt = 1'b0;
        end
      end
      S_OADDR: begin
        state_nxt = S_ORD;
      end
      S_ORD: begin
        tat_nxt   = fin_rdata - TIME_W'(arr_rd);
        resp_nxt  = st_rdata - TIME_W'(arr_rd);
        st_nxt    = st_rdata;
        fin_nxt   = fin_rdata;
        bur_nxt   = bur_rd;
        state_nxt = S_OWT;
      end
      S_OWT: begin
        wt_nxt    = tat_r - TIME_W'(bur_r);
        state_nxt = S_OSUM;
      end
      S_OSUM: begin
        totw_nxt                 = totw_r + srtf_pkg::TOTAL_BITS'(wt_r);
        tott_nxt                 = tott_r + srtf_pkg::TOTAL_BITS'(tat_r);
        out_nxt.process_index    = srtf_pkg::INDEX_BITS'(idx_r);
        out_nxt.start_time       = srtf_pkg::TIME_OUT_BITS'(st_r);
        out_nxt.finish_time      = srtf_pkg::TIME_OUT_BITS'(fin_r);
        out_nxt.turnaround_time  = srtf_pkg::TIME_OUT_BITS'(tat_r);
        out_nxt.waiting_time     = srtf_pkg::TIME_OUT_BITS'(wt_r);
        out_nxt.response_time    = srtf_pkg::TIME_OUT_BITS'(resp_r);
        out_nxt.total_waiting    = is_last_out ? totw_nxt : '0;
        out_nxt.total_turnaround = is_last_out ? tott_nxt : '0;
        out_nxt.last_result      = is_last_out;
        out_valid_nxt            = 1'b1;
        state_nxt                = S_OHOLD;
      end
      S_OHOLD: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (is_last_out) begin
            // set finished: back to the reset picture
            state_nxt   = S_LOAD;
            count_nxt   = '0;
            done_nxt    = '0;
            time_nxt    = '0;
            started_nxt = '0;
            totw_nxt    = '0;
            tott_nxt    = '0;
            idx_nxt     = '0;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_OADDR;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      done_r      <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      iss_done_r  <= 1'b0;
      time_r      <= '0;
      started_r   <= '0;
      totw_r      <= '0;
      tott_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      iss_done_r  <= iss_done_nxt;
      time_r      <= time_nxt;
      started_r   <= started_nxt;
      totw_r      <= totw_nxt;
      tott_r      <= tott_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    run_r    <= run_nxt;
    tat_r    <= tat_nxt;
    resp_r   <= resp_nxt;
    wt_r     <= wt_nxt;
    st_r     <= st_nxt;
    fin_r    <= fin_nxt;
    bur_r    <= bur_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
